### design/jos_pkg.sv
// Shared types and constants for the JVM operand stack shuffle unit.
// No dependencies; the other design files that use it refer to this package by scope.
`default_nettype none

package jos_pkg;

   // Sizing
   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int WORD_W              = 64;
   localparam int CMD_W               = 3;
   localparam int STATUS_W            = 2;
   localparam int DEPTH_W_DEFAULT     = $clog2(STACK_DEPTH_DEFAULT + 1);

   // Top-of-stack window: circular register file indexed by stack position mod 8
   localparam int CACHE_SLOTS = 8;
   localparam int SLOT_W      = 3;
   // Window occupancy thresholds (entries from window base to top)
   localparam int FILL_BELOW  = 4;
   localparam int SPILL_ABOVE = 6;

   // Relative write ports of one command: positions depth-3 .. depth+1
   localparam int WR_PORTS = 5;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP2   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DUP    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUP_X1 = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DUP_X2 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_DUP2   = 3'd6;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CAT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd3;

   // One stack entry; cat2 set means category two
   typedef struct packed {
      logic              cat2;
      logic [WORD_W-1:0] value;
   } entry_type;

   // What the executor sees of the stack
   typedef struct packed {
      logic            has1;   // depth >= 1
      logic            has2;   // depth >= 2
      logic            has3;   // depth >= 3
      logic            room1;  // one more entry fits
      logic            room2;  // two more entries fit
      entry_type [2:0] top3;   // [0] is the top
   } view_type;

   // Executor decision for one command
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [1:0]               grow;
      logic [1:0]               shrink;
      logic [WR_PORTS-1:0]      wr_en;    // bit i writes position depth-3+i
      entry_type [WR_PORTS-1:0] wr_data;
      entry_type                top;      // new top entry when depth stays nonzero
   } exec_type;

endpackage

`default_nettype wire

### design/jos_req_if.sv
// Command channel of the JVM operand stack shuffle unit.
// Depends on jos_pkg for field widths.
`default_nettype none

interface jos_req_if;
   logic                          valid;
   logic                          ready;
   logic [jos_pkg::CMD_W-1:0]     command;
   logic [jos_pkg::WORD_W-1:0]    push_value;
   logic                          push_category;

   modport source (output valid, output command, output push_value, output push_category,
                   input ready);
   modport sink   (input valid, input command, input push_value, input push_category,
                   output ready);
endinterface

`default_nettype wire

### design/jos_rsp_if.sv
// Result channel of the JVM operand stack shuffle unit.
// Depends on jos_pkg for field widths; DEPTH_W follows the stack size.
`default_nettype none

interface jos_rsp_if #(
   parameter int DEPTH_W = jos_pkg::DEPTH_W_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [jos_pkg::STATUS_W-1:0]  status;
   logic [DEPTH_W-1:0]            depth;
   logic [jos_pkg::WORD_W-1:0]    top_value;
   logic                          top_category;

   modport source (output valid, output status, output depth, output top_value,
                   output top_category, input ready);
   modport sink   (input valid, input status, input depth, input top_value,
                   input top_category, output ready);
endinterface

`default_nettype wire

### design/jos_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module jos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/jos_exec.sv
// Command executor: category checks, bounds checks and the shuffle of the top entries.
// Depends on jos_pkg (codes, entry/view/exec structs). Purely combinational.
`default_nettype none

module jos_exec (
   input  wire logic [jos_pkg::CMD_W-1:0] command,
   input  wire jos_pkg::entry_type        push_entry,
   input  wire jos_pkg::view_type         view,
   output jos_pkg::exec_type              result
);

   jos_pkg::entry_type t0, t1, t2;

   assign t0 = view.top3[0];
   assign t1 = view.top3[1];
   assign t2 = view.top3[2];

   always_comb begin
      result         = '0;
      result.status  = jos_pkg::ST_OK;
      result.top     = t0;
      result.wr_data = '0;

      case (command)
         jos_pkg::CMD_PUSH: begin
            if (!view.room1) begin
               result.status = jos_pkg::ST_OVER;
            end else begin
               result.grow       = 2'd1;
               result.wr_en[3]   = 1'b1;
               result.wr_data[3] = push_entry;
               result.top        = push_entry;
            end
         end
         jos_pkg::CMD_POP: begin
            if (!view.has1) begin
               result.status = jos_pkg::ST_UNDER;
            end else if (t0.cat2) begin
               result.status = jos_pkg::ST_CAT;
            end else begin
               result.shrink = 2'd1;
               result.top    = t1;
            end
         end
         jos_pkg::CMD_POP2: begin
            if (!view.has1) begin
               result.status = jos_pkg::ST_UNDER;
            end else if (t0.cat2) begin
               result.shrink = 2'd1;
               result.top    = t1;
            end else if (!view.has2) begin
               result.status = jos_pkg::ST_UNDER;
            end else if (t1.cat2) begin
               result.status = jos_pkg::ST_CAT;
            end else begin
               result.shrink = 2'd2;
               result.top    = t2;
            end
         end
         jos_pkg::CMD_DUP: begin
            if (!view.has1) begin
               result.status = jos_pkg::ST_UNDER;
            end else if (t0.cat2) begin
               result.status = jos_pkg::ST_CAT;
            end else if (!view.room1) begin
               result.status = jos_pkg::ST_OVER;
            end else begin
               result.grow       = 2'd1;
               result.wr_en[3]   = 1'b1;
               result.wr_data[3] = t0;
            end
         end
         jos_pkg::CMD_DUP_X1: begin
            if (!view.has2) begin
               result.status = jos_pkg::ST_UNDER;
            end else if (t0.cat2 || t1.cat2) begin
               result.status = jos_pkg::ST_CAT;
            end else if (!view.room1) begin
               result.status = jos_pkg::ST_OVER;
            end else begin
               result.grow    = 2'd1;
               result.wr_en   = 5'b01110;
               result.wr_data[1] = t0;
               result.wr_data[2] = t1;
               result.wr_data[3] = t0;
            end
         end
         jos_pkg::CMD_DUP_X2: begin
            if (!view.has1) begin
               result.status = jos_pkg::ST_UNDER;
            end else if (t0.cat2) begin
               result.status = jos_pkg::ST_CAT;
            end else if (!view.has2) begin
               result.status = jos_pkg::ST_UNDER;
            end else if (t1.cat2) begin
               // second form: one cat1 over one cat2, same shape as dup_x1
               if (!view.room1) begin
                  result.status = jos_pkg::ST_OVER;
               end else begin
                  result.grow       = 2'd1;
                  result.wr_en      = 5'b01110;
                  result.wr_data[1] = t0;
                  result.wr_data[2] = t1;
                  result.wr_data[3] = t0;
               end
            end else if (!view.has3) begin
               result.status = jos_pkg::ST_UNDER;
            end else if (t2.cat2) begin
               result.status = jos_pkg::ST_CAT;
            end else if (!view.room1) begin
               result.status = jos_pkg::ST_OVER;
            end else begin
               result.grow       = 2'd1;
               result.wr_en      = 5'b01111;
               result.wr_data[0] = t0;
               result.wr_data[1] = t2;
               result.wr_data[2] = t1;
               result.wr_data[3] = t0;
            end
         end
         jos_pkg::CMD_DUP2: begin
            if (!view.has1) begin
               result.status = jos_pkg::ST_UNDER;
            end else if (t0.cat2) begin
               if (!view.room1) begin
                  result.status = jos_pkg::ST_OVER;
               end else begin
                  result.grow       = 2'd1;
                  result.wr_en[3]   = 1'b1;
                  result.wr_data[3] = t0;
               end
            end else if (!view.has2) begin
               result.status = jos_pkg::ST_UNDER;
            end else if (t1.cat2) begin
               result.status = jos_pkg::ST_CAT;
            end else if (!view.room2) begin
               result.status = jos_pkg::ST_OVER;
            end else begin
               result.grow       = 2'd2;
               result.wr_en      = 5'b11000;
               result.wr_data[3] = t1;
               result.wr_data[4] = t0;
            end
         end
         default: begin
            // unused code: no change, ok
         end
      endcase
   end

endmodule

`default_nettype wire

### design/jos_rsp_queue.sv
// Two-beat result queue between the executor and the result channel.
// No dependencies.
`default_nettype none

module jos_rsp_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  space,
   input  wire logic             pop,
   output logic                  valid,
   output logic      [WIDTH-1:0] head
);

   logic [1:0]       cnt_ff, cnt_in;
   logic [WIDTH-1:0] slot0_ff, slot0_in;
   logic [WIDTH-1:0] slot1_ff, slot1_in;

   assign space = (cnt_ff != 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign head  = slot0_ff;

   always_comb begin
      cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = (cnt_ff == 2'd2 || !push) ? slot1_ff : push_data;
         if (push && cnt_ff == 2'd2) begin
            slot1_in = push_data;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

### design/jvm_operand_stack_shuffle_unit.sv
// Top level of the JVM operand stack shuffle unit (push/pop/pop2/dup/dup_x1/dup_x2/dup2).
// Depends on jos_pkg, jos_req_if, jos_rsp_if, jos_ram, jos_exec and jos_rsp_queue.
// Usage
//   req_ch carries one command per beat (command, push_value, push_category).
//   rsp_ch returns exactly one beat per command: status, depth after the command,
//   and the new top entry (value and category, both zero on an empty stack).
//   Errors (category, underflow, overflow) leave the stack untouched.
// Timing
//   A command accepted into the input register executes there once the result queue
//   has space, and its result is written into the queue that drives rsp_ch. Throughput
//   is one command per cycle while rsp_ch keeps up, independent of the command mix.
//   The top of stack lives in an 8-slot register window indexed by position mod 8;
//   deeper entries live in two RAM banks (even and odd positions), so two entries
//   spill or refill per cycle and keep pace with the +/-2 entries a command can move.
//   A refill read lands in the next cycle and is forwarded straight from the RAM.
// Reset
//   Synchronous reset empties the stack at once; there is no clearing pass, the
//   stack RAM is only ever read where it was written first.
// Backpressure
//   A two-beat result queue plus the input register absorb a stalled receiver;
//   req_ch.ready drops only once both are full and comes back in the cycle after a
//   result leaves.
`default_nettype none

module jvm_operand_stack_shuffle_unit #(
   parameter int STACK_DEPTH = jos_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   jos_req_if.sink    req_ch,
   jos_rsp_if.source  rsp_ch
);

   localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
   localparam int BANK_DEPTH = (STACK_DEPTH + 1) / 2;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int SLOTS      = jos_pkg::CACHE_SLOTS;
   localparam int SW         = jos_pkg::SLOT_W;
   localparam int PORTS      = jos_pkg::WR_PORTS;
   localparam int ENTRY_W    = $bits(jos_pkg::entry_type);
   localparam int RSP_W      = jos_pkg::STATUS_W + DEPTH_W + jos_pkg::WORD_W + 1;

   localparam logic [DEPTH_W-1:0] SD_LIMIT = DEPTH_W'(STACK_DEPTH);

   // ---------------- input register ----------------
   logic                        in_valid_ff, in_valid_in;
   logic [jos_pkg::CMD_W-1:0]   in_cmd_ff;
   jos_pkg::entry_type          in_push_ff;
   logic                        req_fire;
   logic                        go;          // execute the registered command this cycle
   logic                        out_space;

   assign go           = in_valid_ff && out_space;
   assign req_ch.ready = !in_valid_ff || go;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !go);

   // ---------------- stack state ----------------
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [DEPTH_W-1:0]  base_ff, base_in;   // lowest position held by the window (even)
   logic                pend_ff, pend_in;   // refill pair base, base+1 arrives from RAM
   jos_pkg::entry_type  slot_ff [SLOTS];
   jos_pkg::entry_type  slot_in [SLOTS];
   jos_pkg::entry_type  eff     [SLOTS];    // window contents with refill forwarded
   jos_pkg::entry_type  ram_rd  [2];

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         if (pend_ff && SW'(s) >> 1 == base_ff[SW-1:0] >> 1) begin
            eff[s] = ram_rd[s % 2];
         end else begin
            eff[s] = slot_ff[s];
         end
      end
   end

   // ---------------- view of the top three ----------------
   logic [DEPTH_W-1:0]  rd_pos [3];
   jos_pkg::view_type   view;
   jos_pkg::exec_type   exec;
   logic [DEPTH_W:0]    depth_plus2;

   assign depth_plus2 = {1'b0, depth_ff} + (DEPTH_W + 1)'(2);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rd_pos[k]    = depth_ff - DEPTH_W'(k + 1);
         view.top3[k] = eff[rd_pos[k][SW-1:0]];
      end
      view.has1  = (depth_ff != '0);
      view.has2  = (depth_ff >= DEPTH_W'(2));
      view.has3  = (depth_ff >= DEPTH_W'(3));
      view.room1 = (depth_ff < SD_LIMIT);
      view.room2 = (depth_plus2 <= (DEPTH_W + 1)'(STACK_DEPTH));
   end

   jos_exec u_exec (
      .command    (in_cmd_ff),
      .push_entry (in_push_ff),
      .view       (view),
      .result     (exec)
   );

   logic commit;
   assign commit = go && (exec.status == jos_pkg::ST_OK);

   // ---------------- window update ----------------
   logic [DEPTH_W-1:0] wr_pos [PORTS];

   always_comb begin
      for (int i = 0; i < PORTS; i++) begin
         wr_pos[i] = depth_ff - DEPTH_W'(3) + DEPTH_W'(i);
      end
      for (int s = 0; s < SLOTS; s++) begin
         slot_in[s] = eff[s];   // lands a pending refill
         for (int i = 0; i < PORTS; i++) begin
            if (commit && exec.wr_en[i] && wr_pos[i][SW-1:0] == SW'(s)) begin
               slot_in[s] = exec.wr_data[i];
            end
         end
      end
   end

   assign depth_in = commit ? depth_ff + DEPTH_W'(exec.grow) - DEPTH_W'(exec.shrink)
                            : depth_ff;

   // ---------------- spill / refill ----------------
   // Window occupancy after this command is kept in [4,6] when deep enough, so the
   // next command always finds its top three entries and never outgrows 8 slots.
   logic [DEPTH_W-1:0] occ;
   logic               fill, spill;
   logic [DEPTH_W-1:0] fill_pos;
   logic [SW-1:0]      base_slot_even, base_slot_odd;

   assign occ      = depth_in - base_ff;
   assign fill     = (occ < DEPTH_W'(jos_pkg::FILL_BELOW)) && (base_ff != '0);
   assign spill    = (occ > DEPTH_W'(jos_pkg::SPILL_ABOVE));
   assign fill_pos = base_ff - DEPTH_W'(2);

   assign base_slot_even = {base_ff[SW-1:1], 1'b0};
   assign base_slot_odd  = {base_ff[SW-1:1], 1'b1};

   always_comb begin
      base_in = base_ff;
      if (fill) begin
         base_in = fill_pos;
      end else if (spill) begin
         base_in = base_ff + DEPTH_W'(2);
      end
   end
   assign pend_in = fill;

   logic [ENTRY_W-1:0] ram_rd_raw [2];

   jos_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_bank_even (
      .clock   (clock),
      .wr_en   (spill),
      .wr_addr (base_ff[BANK_AW:1]),
      .wr_data (eff[base_slot_even]),
      .rd_en   (fill),
      .rd_addr (fill_pos[BANK_AW:1]),
      .rd_data (ram_rd_raw[0])
   );

   jos_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_bank_odd (
      .clock   (clock),
      .wr_en   (spill),
      .wr_addr (base_ff[BANK_AW:1]),
      .wr_data (eff[base_slot_odd]),
      .rd_en   (fill),
      .rd_addr (fill_pos[BANK_AW:1]),
      .rd_data (ram_rd_raw[1])
   );

   assign ram_rd[0] = ram_rd_raw[0];
   assign ram_rd[1] = ram_rd_raw[1];

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         depth_ff    <= '0;
         base_ff     <= '0;
         pend_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         depth_ff    <= depth_in;
         base_ff     <= base_in;
         pend_ff     <= pend_in;
      end
      if (req_fire) begin
         in_cmd_ff        <= req_ch.command;
         in_push_ff.value <= req_ch.push_value;
         in_push_ff.cat2  <= req_ch.push_category;
      end
      for (int s = 0; s < SLOTS; s++) begin
         slot_ff[s] <= slot_in[s];
      end
   end

   // ---------------- result queue ----------------
   logic [RSP_W-1:0]   rsp_beat, rsp_head;
   jos_pkg::entry_type top_out;

   assign top_out  = (depth_in == '0) ? '0 : exec.top;
   assign rsp_beat = {exec.status, depth_in, top_out.value, top_out.cat2};

   jos_rsp_queue #(.WIDTH(RSP_W)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (go),
      .push_data (rsp_beat),
      .space     (out_space),
      .pop       (rsp_ch.valid && rsp_ch.ready),
      .valid     (rsp_ch.valid),
      .head      (rsp_head)
   );

   assign {rsp_ch.status, rsp_ch.depth, rsp_ch.top_value, rsp_ch.top_category} = rsp_head;

endmodule

`default_nettype wire

### design/jos_checker.sv
// Port-level checks for the JVM operand stack shuffle unit, bound to the top level.
// Depends on jos_pkg (status codes) and jvm_operand_stack_shuffle_unit.
`default_nettype none

module jos_checker #(
   parameter int STACK_DEPTH = jos_pkg::STACK_DEPTH_DEFAULT,
   parameter int DEPTH_W     = jos_pkg::DEPTH_W_DEFAULT
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [jos_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [DEPTH_W-1:0]           rsp_depth,
   input wire logic [jos_pkg::WORD_W-1:0]   rsp_top_value,
   input wire logic                         rsp_top_category
);

   logic               rsp_fire;
   logic               seen_ff;
   logic [DEPTH_W-1:0] last_depth_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_fire) begin
         seen_ff <= 1'b1;
      end
      if (rsp_fire) begin
         last_depth_ff <= rsp_depth;
      end
   end

   // a failed command leaves the depth as the previous beat reported it
   a_error_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_ff && rsp_status != jos_pkg::ST_OK |-> rsp_depth == last_depth_ff)
      else $error("depth changed on a failed command");

   a_empty_top_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_depth == '0 |-> rsp_top_value == '0 && !rsp_top_category)
      else $error("nonzero top on an empty stack");

   a_overflow_near_full: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_status == jos_pkg::ST_OVER
      |-> ({1'b0, rsp_depth} + (DEPTH_W + 1)'(1)) >= (DEPTH_W + 1)'(STACK_DEPTH))
      else $error("overflow reported with room left");

   a_depth_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_depth} <= (DEPTH_W + 1)'(STACK_DEPTH))
      else $error("depth beyond stack size");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind jvm_operand_stack_shuffle_unit jos_checker #(
   .STACK_DEPTH (STACK_DEPTH),
   .DEPTH_W     (DEPTH_W)
) u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_depth        (rsp_ch.depth),
   .rsp_top_value    (rsp_ch.top_value),
   .rsp_top_category (rsp_ch.top_category)
);

`default_nettype wire
